FILE: rtl/core/clcb_pkg.sv
// Shared constants, command codes and controller/datapath link types.
package clcb_pkg;

   localparam int CMD_W       = 2;
   localparam int MODEL_W     = 8;
   localparam int LEVEL_W     = 4;
   localparam int FLAGS_W     = 8;
   localparam int PENDING_W   = 6;
   localparam int VISIBLE_W   = 9;
   localparam int THRESH_W    = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CMD_W-1:0] CMD_LOAD        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PROPOSE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH_DUE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH_FORCE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLUSH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODEL_COUNT     = 2'd2;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic seq_start;
      logic scan_step;
      logic write_update;
      logic dec_total;
      logic rm_read;
      logic move_write;
      logic set_drop;
      logic tbl_read;
      logic append;
      logic walk_step;
      logic count_start;
      logic count_step;
      logic set_flush;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd_code;
      logic             in_range;
      logic             due;
      logic             scan_hit;
      logic             scan_miss;
      logic             restore;
      logic             hit_last;
      logic             full;
      logic             walk_done;
      logic             count_done;
   } dp_stat_type;

endpackage

FILE: rtl/core/clcb_req_if.sv
// Request channel: valid/ready handshake with the proposal payload.
interface clcb_req_if;
   import clcb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [MODEL_W-1:0]        model_index;
   logic signed [LEVEL_W-1:0] level;
   logic [FLAGS_W-1:0]        flags;

   modport source (output valid, command, model_index, level, flags, input ready);
   modport sink   (input valid, command, model_index, level, flags, output ready);
endinterface

FILE: rtl/core/clcb_rsp_if.sv
// Response channel: valid/ready handshake with the per-request status.
interface clcb_rsp_if;
   import clcb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PENDING_W-1:0] pending_count;
   logic [VISIBLE_W-1:0] visible_count;
   logic                 flushed;
   logic                 all_hidden;
   logic                 dropped;

   modport source (output valid, pending_count, visible_count, flushed, all_hidden, dropped,
                   input ready);
   modport sink   (input valid, pending_count, visible_count, flushed, all_hidden, dropped,
                   output ready);
endinterface

FILE: rtl/core/clcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/clcb_datapath.sv
// Datapath: tables, pending buffer, counters, config and response registers.
module clcb_datapath #(
   parameter int MAX_MODELS  = 256,
   parameter int MAX_PENDING = 32,
   parameter int FLAG_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  clcb_pkg::ctrl_cmd_type              cmd,
   output clcb_pkg::dp_stat_type               stat,
   input  logic [clcb_pkg::CMD_W-1:0]          req_command,
   input  logic [clcb_pkg::MODEL_W-1:0]        req_model_index,
   input  logic signed [clcb_pkg::LEVEL_W-1:0] req_level,
   input  logic [clcb_pkg::FLAGS_W-1:0]        req_flags,
   input  logic                                csr_we,
   input  logic [clcb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [clcb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [clcb_pkg::PENDING_W-1:0]      rsp_pending_count,
   output logic [clcb_pkg::VISIBLE_W-1:0]      rsp_visible_count,
   output logic                                rsp_flushed,
   output logic                                rsp_all_hidden,
   output logic                                rsp_dropped
);
   import clcb_pkg::*;

   localparam int AW  = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
   localparam int PIW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
   localparam int PW  = $clog2(MAX_PENDING + 1);
   localparam int NW  = $clog2(MAX_MODELS + 1);

   typedef struct packed {
      logic [AW-1:0]        model;
      logic [LEVEL_W-1:0]   old_level;
      logic [LEVEL_W-1:0]   new_level;
      logic [FLAG_BITS-1:0] old_flags;
      logic [FLAG_BITS-1:0] new_flags;
   } entry_type;

   localparam int EW = $bits(entry_type);

   // captured request
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [MODEL_W-1:0]   m_ff, m_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [FLAG_BITS-1:0] flg_ff, flg_in;

   // config
   logic [THRESH_W-1:0]   thr_ff, thr_in;
   logic                  en_ff, en_in;
   logic [CSR_DATA_W-1:0] mc_ff, mc_in;

   // sequencing
   logic [PW-1:0]  total_ff, total_in;
   logic [NW-1:0]  vis_ff, vis_in;
   logic [PW-1:0]  idx_ff, idx_in;
   logic [PIW-1:0] chk_ff, chk_in;
   logic [PIW-1:0] hit_ff, hit_in;
   logic [NW-1:0]  cidx_ff, cidx_in;
   logic           rdv_ff, rdv_in;
   logic           flushed_ff, flushed_in;
   logic           dropped_ff, dropped_in;

   // response payload
   logic [PENDING_W-1:0] out_pend_ff;
   logic [VISIBLE_W-1:0] out_vis_ff;
   logic                 out_flushed_ff, out_hidden_ff, out_dropped_ff;

   logic [AW-1:0]        m_idx;
   logic [NW-1:0]        n_use;
   logic                 load_ok;
   entry_type            pend_rd, pend_wdata;
   logic [EW-1:0]        pend_rdata;
   logic                 pend_we;
   logic [PIW-1:0]       pend_waddr, pend_raddr;
   logic [LEVEL_W-1:0]   lvl_rdata, lvl_wdata;
   logic [FLAG_BITS-1:0] flg_rdata;
   logic                 lvl_we;
   logic [AW-1:0]        lvl_waddr, lvl_raddr;

   assign m_idx   = AW'(m_ff);
   assign n_use   = (32'(mc_ff) > 32'(MAX_MODELS)) ? NW'(MAX_MODELS) : NW'(mc_ff);
   assign load_ok = 32'(m_ff) < 32'(MAX_MODELS);
   assign pend_rd = pend_rdata;

   // status
   always_comb begin
      stat.cmd_code   = cmd_ff;
      stat.in_range   = 32'(m_ff) < 32'(n_use);
      stat.due        = (cmd_ff == CMD_FLUSH_FORCE) ||
                        (en_ff && (32'(total_ff) >= 32'(thr_ff)));
      stat.scan_hit   = rdv_ff && (pend_rd.model == m_idx);
      stat.scan_miss  = !rdv_ff && (idx_ff == total_ff);
      stat.restore    = (pend_rd.old_level == lvl_ff) && (pend_rd.old_flags == flg_ff);
      stat.hit_last   = (32'(chk_ff) + 32'd1) == 32'(total_ff);
      stat.full       = 32'(total_ff) >= 32'(MAX_PENDING);
      stat.walk_done  = !rdv_ff && (idx_ff == total_ff);
      stat.count_done = !rdv_ff && (cidx_ff == n_use);
   end

   // pending buffer ports
   always_comb begin
      pend_raddr = cmd.rm_read ? total_ff[PIW-1:0] : idx_ff[PIW-1:0];
      pend_we    = cmd.write_update || cmd.move_write || cmd.append;
      pend_waddr = total_ff[PIW-1:0];
      pend_wdata = pend_rd;
      if (cmd.write_update) begin
         pend_waddr           = chk_ff;
         pend_wdata.new_level = lvl_ff;
         pend_wdata.new_flags = flg_ff;
      end else if (cmd.move_write) begin
         pend_waddr = hit_ff;
      end else if (cmd.append) begin
         pend_wdata.model     = m_idx;
         pend_wdata.old_level = lvl_rdata;
         pend_wdata.new_level = lvl_ff;
         pend_wdata.old_flags = flg_rdata;
         pend_wdata.new_flags = flg_ff;
      end
   end

   // table ports: loads and flush walk write, append and count read
   always_comb begin
      lvl_raddr = cmd.tbl_read ? m_idx : cidx_ff[AW-1:0];
      lvl_we    = (cmd.load_write && load_ok) || (cmd.walk_step && rdv_ff);
      lvl_waddr = cmd.load_write ? m_idx : pend_rd.model;
      lvl_wdata = cmd.load_write ? lvl_ff : pend_rd.new_level;
   end

   clcb_ram #(.WIDTH(EW), .DEPTH(MAX_PENDING)) u_pend_ram (
      .clock (clock),
      .we    (pend_we),
      .waddr (pend_waddr),
      .wdata (pend_wdata),
      .raddr (pend_raddr),
      .rdata (pend_rdata)
   );

   clcb_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_MODELS)) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   clcb_ram #(.WIDTH(FLAG_BITS), .DEPTH(MAX_MODELS)) u_flag_ram (
      .clock (clock),
      .we    (cmd.load_write && load_ok),
      .waddr (m_idx),
      .wdata (flg_ff),
      .raddr (m_idx),
      .rdata (flg_rdata)
   );

   always_comb begin
      cmd_in     = cmd_ff;
      m_in       = m_ff;
      lvl_in     = lvl_ff;
      flg_in     = flg_ff;
      thr_in     = thr_ff;
      en_in      = en_ff;
      mc_in      = mc_ff;
      total_in   = total_ff;
      vis_in     = vis_ff;
      idx_in     = idx_ff;
      chk_in     = chk_ff;
      hit_in     = hit_ff;
      cidx_in    = cidx_ff;
      rdv_in     = rdv_ff;
      flushed_in = flushed_ff;
      dropped_in = dropped_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FLUSH_THRESHOLD: thr_in = csr_wdata[THRESH_W-1:0];
            CSR_ENABLED:         en_in  = csr_wdata[0];
            CSR_MODEL_COUNT:     mc_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         cmd_in     = req_command;
         m_in       = req_model_index;
         lvl_in     = $unsigned(req_level);
         flg_in     = FLAG_BITS'(req_flags);
         flushed_in = 1'b0;
         dropped_in = 1'b0;
      end

      if (cmd.seq_start) begin
         idx_in = '0;
         rdv_in = 1'b0;
      end

      // one read issued per cycle, checked when its data returns
      if (cmd.scan_step || cmd.walk_step) begin
         if (cmd.scan_step && stat.scan_hit) begin
            hit_in = chk_ff;
            rdv_in = 1'b0;
         end else if (idx_ff < total_ff) begin
            rdv_in = 1'b1;
            chk_in = idx_ff[PIW-1:0];
            idx_in = idx_ff + PW'(1);
         end else begin
            rdv_in = 1'b0;
         end
      end

      if (cmd.dec_total) total_in = total_ff - PW'(1);
      if (cmd.append)    total_in = total_ff + PW'(1);
      if (cmd.set_drop)  dropped_in = 1'b1;
      if (cmd.set_flush) flushed_in = 1'b1;

      if (cmd.count_start) begin
         total_in = '0;
         vis_in   = '0;
         cidx_in  = '0;
         rdv_in   = 1'b0;
      end

      if (cmd.count_step) begin
         if (rdv_ff && !lvl_rdata[LEVEL_W-1]) begin
            vis_in = vis_ff + NW'(1);
         end
         if (cidx_ff < n_use) begin
            rdv_in  = 1'b1;
            cidx_in = cidx_ff + NW'(1);
         end else begin
            rdv_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THRESH_W'(1);
         en_ff      <= 1'b0;
         mc_ff      <= '0;
         total_ff   <= '0;
         vis_ff     <= '0;
         idx_ff     <= '0;
         cidx_ff    <= '0;
         rdv_ff     <= 1'b0;
         flushed_ff <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         thr_ff     <= thr_in;
         en_ff      <= en_in;
         mc_ff      <= mc_in;
         total_ff   <= total_in;
         vis_ff     <= vis_in;
         idx_ff     <= idx_in;
         cidx_ff    <= cidx_in;
         rdv_ff     <= rdv_in;
         flushed_ff <= flushed_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      m_ff   <= m_in;
      lvl_ff <= lvl_in;
      flg_ff <= flg_in;
      chk_ff <= chk_in;
      hit_ff <= hit_in;
      if (cmd.emit) begin
         out_pend_ff    <= PENDING_W'(total_ff);
         out_vis_ff     <= VISIBLE_W'(vis_ff);
         out_flushed_ff <= flushed_ff;
         out_hidden_ff  <= flushed_ff && (vis_ff == '0);
         out_dropped_ff <= dropped_ff;
      end
   end

   assign rsp_pending_count = out_pend_ff;
   assign rsp_visible_count = out_vis_ff;
   assign rsp_flushed       = out_flushed_ff;
   assign rsp_all_hidden    = out_hidden_ff;
   assign rsp_dropped       = out_dropped_ff;
endmodule

FILE: rtl/core/clcb_ctrl.sv
// Controller: sequences one request at a time over the datapath.
module clcb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  clcb_pkg::dp_stat_type  stat,
   output clcb_pkg::ctrl_cmd_type cmd
);
   import clcb_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_RM_RD    = 4'd3;
   localparam logic [3:0] S_RM_WR    = 4'd4;
   localparam logic [3:0] S_APPEND   = 4'd5;
   localparam logic [3:0] S_WALK     = 4'd6;
   localparam logic [3:0] S_COUNT    = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.cmd_code)
               CMD_LOAD: begin
                  cmd.load_write = 1'b1;
                  state_in       = S_FINISH;
               end
               CMD_PROPOSE: begin
                  if (stat.in_range) begin
                     cmd.seq_start = 1'b1;
                     state_in      = S_SCAN;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               CMD_FLUSH_DUE, CMD_FLUSH_FORCE: begin
                  if (stat.due) begin
                     cmd.seq_start = 1'b1;
                     state_in      = S_WALK;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               if (stat.restore) begin
                  // drop the entry; the last one fills its slot unless the dropped entry was the last
                  cmd.dec_total = 1'b1;
                  state_in      = stat.hit_last ? S_FINISH : S_RM_RD;
               end else begin
                  cmd.write_update = 1'b1;
                  state_in         = S_FINISH;
               end
            end else if (stat.scan_miss) begin
               if (stat.full) begin
                  cmd.set_drop = 1'b1;
                  state_in     = S_FINISH;
               end else begin
                  cmd.tbl_read = 1'b1;
                  state_in     = S_APPEND;
               end
            end
         end
         S_RM_RD: begin
            cmd.rm_read = 1'b1;
            state_in    = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.move_write = 1'b1;
            state_in       = S_FINISH;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_FINISH;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               cmd.count_start = 1'b1;
               state_in        = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.count_done) begin
               cmd.set_flush = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: rtl/core/coalescing_level_change_buffer_unit.sv
// Top level: coalescing level-change buffer, controller plus datapath.
//
//   channel   dir   handshake            payload
//   req_chan  in    valid/ready          command, model_index, level, flags
//   rsp_chan  out   valid/ready          pending_count, visible_count, flushed,
//                                         all_hidden, dropped
//   csr_*     in    csr_we, no back-pressure   csr_index, csr_wdata
//
// One request at a time. Load and refused requests go straight to the response. Propose scans
// the pending entries: a hit updates the entry, or drops it and moves the last one into its slot
// if the old values are restored; a miss appends after a table read, or drops when full. Flush
// writes each entry back, then counts visible models in use; each store has one read port.
// Reset is synchronous and empties the buffer; tables hold nothing until loaded. A waiting
// response does not block the next request; completion waits for the response register.
module coalescing_level_change_buffer_unit #(
   parameter int MAX_MODELS  = 256,
   parameter int MAX_PENDING = 32,
   parameter int FLAG_BITS   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   clcb_req_if.sink                         req_chan,
   clcb_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [clcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import clcb_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   clcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clcb_datapath #(
      .MAX_MODELS  (MAX_MODELS),
      .MAX_PENDING (MAX_PENDING),
      .FLAG_BITS   (FLAG_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_command       (req_chan.command),
      .req_model_index   (req_chan.model_index),
      .req_level         (req_chan.level),
      .req_flags         (req_chan.flags),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_pending_count (rsp_chan.pending_count),
      .rsp_visible_count (rsp_chan.visible_count),
      .rsp_flushed       (rsp_chan.flushed),
      .rsp_all_hidden    (rsp_chan.all_hidden),
      .rsp_dropped       (rsp_chan.dropped)
   );
endmodule

FILE: rtl/core/clcb_checker.sv
// Port-level checks on the top level, attached by bind.
module clcb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [clcb_pkg::PENDING_W-1:0] pending_count,
   input logic [clcb_pkg::VISIBLE_W-1:0] visible_count,
   input logic                           flushed,
   input logic                           all_hidden,
   input logic                           dropped
);
   import clcb_pkg::*;

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight: no request taken on the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && flushed |-> (pending_count == '0) && !dropped)
      else $error("flush left changes pending");

   a_hidden_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && all_hidden |-> flushed && (visible_count == '0))
      else $error("all_hidden without an empty flush");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind coalescing_level_change_buffer_unit clcb_checker u_clcb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .pending_count (rsp_chan.pending_count),
   .visible_count (rsp_chan.visible_count),
   .flushed       (rsp_chan.flushed),
   .all_hidden    (rsp_chan.all_hidden),
   .dropped       (rsp_chan.dropped)
);

FILE: tb/level_change_checker.sv
// Response checker: predicts the level-change buffer's status for each request and compares.
`timescale 1ns / 1ps
module level_change_checker #(
   parameter int TABLE_DEPTH  = 256,
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   clcb_req_if                              req_mon,
   clcb_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [clcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             run_over,
   output int                               failures,
   output int                               flush_total,
   output int                               drop_total,
   output int                               removal_total
);
   import clcb_pkg::*;

   typedef struct packed {
      logic [PENDING_W-1:0] pending_count;
      logic [VISIBLE_W-1:0] visible_count;
      logic                 flushed;
      logic                 all_hidden;
      logic                 dropped;
   } status_type;

   typedef struct packed {
      logic [MODEL_W-1:0] model;
      logic [LEVEL_W-1:0] old_level;
      logic [LEVEL_W-1:0] new_level;
      logic [FLAGS_W-1:0] old_flags;
      logic [FLAGS_W-1:0] new_flags;
   } change_type;

   logic [LEVEL_W-1:0]   level_shadow [TABLE_DEPTH];
   logic [FLAGS_W-1:0]   flag_shadow  [TABLE_DEPTH];
   change_type           changes      [BUFFER_DEPTH];
   int unsigned          change_total;
   int unsigned          visible_total;
   logic [THRESH_W-1:0]  threshold;
   logic                 enable_q;
   logic [VISIBLE_W-1:0] model_count;
   status_type           expected_status [$];
   int                   response_seq;
   bit                   leftover_done;

   function automatic int unsigned models_in_use();
      return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
   endfunction

   function automatic void flush_changes();
      int unsigned i;
      for (i = 0; i < change_total; i++)
         level_shadow[changes[i].model] = changes[i].new_level;
      change_total  = 0;
      visible_total = 0;
      for (i = 0; i < models_in_use(); i++)
         if (!level_shadow[i][LEVEL_W-1])
            visible_total++;
   endfunction

   // Returns 1 when a new change finds the buffer full.
   function automatic bit propose_change(logic [MODEL_W-1:0] m, logic [LEVEL_W-1:0] lvl,
                                         logic [FLAGS_W-1:0] flg);
      int unsigned i;
      if (m >= models_in_use())
         return 1'b0;
      for (i = 0; i < change_total; i++) begin
         if (changes[i].model == m) begin
            if (changes[i].old_level == lvl && changes[i].old_flags == flg) begin
               // back to the recorded values: last entry fills the hole
               change_total--;
               changes[i] = changes[change_total];
               removal_total++;
            end else begin
               changes[i].new_level = lvl;
               changes[i].new_flags = flg;
            end
            return 1'b0;
         end
      end
      if (change_total >= BUFFER_DEPTH)
         return 1'b1;
      changes[change_total] = '{model: m, old_level: level_shadow[m], new_level: lvl,
                                old_flags: flag_shadow[m], new_flags: flg};
      change_total++;
      return 1'b0;
   endfunction

   function automatic status_type apply_request(logic [CMD_W-1:0] cmd,
                                                logic [MODEL_W-1:0] m,
                                                logic [LEVEL_W-1:0] lvl,
                                                logic [FLAGS_W-1:0] flg);
      status_type s;
      s = '0;
      case (cmd)
         CMD_LOAD: begin
            level_shadow[m] = lvl;
            flag_shadow[m]  = flg;
         end
         CMD_PROPOSE: begin
            s.dropped = propose_change(m, lvl, flg);
            if (s.dropped)
               drop_total++;
         end
         default: begin
            if (cmd == CMD_FLUSH_FORCE || (enable_q && change_total >= threshold)) begin
               flush_changes();
               s.flushed    = 1'b1;
               s.all_hidden = (visible_total == 0);
               flush_total++;
            end
         end
      endcase
      s.pending_count = PENDING_W'(change_total);
      s.visible_count = VISIBLE_W'(visible_total);
      return s;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(string name, logic [VISIBLE_W-1:0] got, logic [VISIBLE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d: %s is %0d, expected %0d",
                                   response_seq, name, got, want));
   endtask

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         change_total  = 0;
         visible_total = 0;
         threshold     = THRESH_W'(1);
         enable_q      = 1'b0;
         model_count   = '0;
         response_seq  = 0;
         failures      = 0;
         flush_total   = 0;
         drop_total    = 0;
         removal_total = 0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FLUSH_THRESHOLD: threshold   = csr_wdata[THRESH_W-1:0];
               CSR_ENABLED:         enable_q    = csr_wdata[0];
               CSR_MODEL_COUNT:     model_count = csr_wdata[VISIBLE_W-1:0];
               default: ;
            endcase
         end
         // responses first: one leaving now belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.pending_count, rsp_mon.visible_count, rsp_mon.flushed,
                   rsp_mon.all_hidden, rsp_mon.dropped};
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request waiting",
                                         response_seq));
            end else begin
               want = expected_status.pop_front();
               check_field("pending_count", got.pending_count, want.pending_count);
               check_field("visible_count", got.visible_count, want.visible_count);
               check_field("flushed", got.flushed, want.flushed);
               check_field("all_hidden", got.all_hidden, want.all_hidden);
               check_field("dropped", got.dropped, want.dropped);
            end
            response_seq++;
         end
         if (req_mon.valid && req_mon.ready)
            expected_status.push_back(apply_request(req_mon.command, req_mon.model_index,
                                                    req_mon.level, req_mon.flags));
         if (run_over && !leftover_done) begin
            leftover_done = 1'b1;
            if (expected_status.size() != 0)
               report_mismatch($sformatf("%0d responses never arrived",
                                         expected_status.size()));
         end
      end
   end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, request stimulus, response pacing and the verdict.
`timescale 1ns / 1ps
module testbench;
   import clcb_pkg::*;

   localparam int TABLE_DEPTH    = 256;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   run_over;

   int failures, flush_total, drop_total, removal_total;
   int requests_sent, responses_taken, idle_cycles;
   int settings_used;
   int model_limit;
   bit req_steady, rsp_steady, rsp_hold;

   // what each table entry was last loaded with, for proposals that put it back
   logic [LEVEL_W-1:0] loaded_level [TABLE_DEPTH];
   logic [FLAGS_W-1:0] loaded_flags [TABLE_DEPTH];
   bit                 loaded       [TABLE_DEPTH];
   bit                 proposed     [TABLE_DEPTH];

   clcb_req_if req_chan ();
   clcb_rsp_if rsp_chan ();

   coalescing_level_change_buffer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   level_change_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .run_over      (run_over),
      .failures      (failures),
      .flush_total   (flush_total),
      .drop_total    (drop_total),
      .removal_total (removal_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         requests_sent   <= 0;
         responses_taken <= 0;
         idle_cycles     <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            requests_sent <= requests_sent + 1;
         if (rsp_chan.valid && rsp_chan.ready)
            responses_taken <= responses_taken + 1;
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side: random hold-offs, steady stretches and one long hold on request
   initial begin : response_pacing
      int gap;
      rsp_chan.ready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = rsp_steady ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [MODEL_W-1:0] idx,
                               logic [LEVEL_W-1:0] lvl, logic [FLAGS_W-1:0] flg);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.model_index <= idx;
      req_chan.level       <= lvl;
      req_chan.flags       <= flg;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_LOAD) begin
         loaded[idx]       = 1'b1;
         loaded_level[idx] = lvl;
         loaded_flags[idx] = flg;
         proposed[idx]     = 1'b0;
      end else if (cmd == CMD_PROPOSE) begin
         proposed[idx] = 1'b1;
      end
   endtask

   task automatic wait_all_answered();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (requests_sent != responses_taken)
         @(posedge clock);
   endtask

   task automatic set_registers(int thr, bit en, int mc);
      wait_all_answered();
      csr_we    <= 1'b1;
      csr_index <= CSR_FLUSH_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index <= CSR_ENABLED;
      csr_wdata <= CSR_DATA_W'(en);
      @(posedge clock);
      csr_index <= CSR_MODEL_COUNT;
      csr_wdata <= CSR_DATA_W'(mc);
      @(posedge clock);
      csr_we <= 1'b0;
      model_limit = (mc > TABLE_DEPTH) ? TABLE_DEPTH : mc;
      settings_used++;
   endtask

   function automatic logic [LEVEL_W-1:0] random_level();
      if ($urandom_range(0, 9) == 0)
         return LEVEL_W'($urandom_range(0, 15));
      return LEVEL_W'($urandom_range(0, 8) - 1);
   endfunction

   // every entry in use must hold something before a proposal or flush reads it
   task automatic load_models(int upto);
      for (int m = 0; m < upto; m++)
         if (!loaded[m])
            send_request(CMD_LOAD, MODEL_W'(m), random_level(), FLAGS_W'($urandom));
   endtask

   task automatic random_request(int prop_pct, int flush_pct);
      int                 pick;
      logic [MODEL_W-1:0] idx;
      pick = $urandom_range(0, 99);
      idx  = MODEL_W'($urandom);
      if (pick < prop_pct) begin
         if (model_limit != 0 && $urandom_range(0, 9) != 0)
            idx = MODEL_W'($urandom_range(0, model_limit - 1));
         if (proposed[idx] && loaded[idx] && $urandom_range(0, 2) == 0)
            send_request(CMD_PROPOSE, idx, loaded_level[idx], loaded_flags[idx]);
         else
            send_request(CMD_PROPOSE, idx, random_level(), FLAGS_W'($urandom));
      end else if (pick < prop_pct + flush_pct) begin
         send_request(($urandom_range(0, 2) == 0) ? CMD_FLUSH_FORCE : CMD_FLUSH_DUE,
                      idx, random_level(), FLAGS_W'($urandom));
      end else begin
         send_request(CMD_LOAD, idx, random_level(), FLAGS_W'($urandom));
      end
   endtask

   task automatic run_phase(int thr, bit en, int mc, int count, int prop_pct, int flush_pct);
      load_models((mc > TABLE_DEPTH) ? TABLE_DEPTH : mc);
      set_registers(thr, en, mc);
      req_steady = ($urandom_range(0, 3) == 0);
      rsp_steady = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         if ($urandom_range(0, 39) == 0)
            wait_all_answered();
         if ($urandom_range(0, 29) == 0)
            req_steady = !req_steady;
         if ($urandom_range(0, 29) == 0)
            rsp_steady = !rsp_steady;
         random_request(prop_pct, flush_pct);
      end
   endtask

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_LOAD;
      req_chan.model_index <= '0;
      req_chan.level       <= '0;
      req_chan.flags       <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_FLUSH_THRESHOLD;
      csr_wdata            <= '0;
      run_over             <= 1'b0;
      model_limit = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nothing in use yet: empty flushes, proposal outside the models in use, then table loads
      send_request(CMD_FLUSH_FORCE, 8'd0, 4'd0, 8'h00);
      send_request(CMD_FLUSH_DUE, 8'd0, 4'd0, 8'h00);
      send_request(CMD_PROPOSE, 8'd0, 4'd3, 8'h0F);
      send_request(CMD_LOAD, 8'd0, 4'd7, 8'hFF);
      send_request(CMD_LOAD, 8'd1, 4'hF, 8'h00);
      send_request(CMD_LOAD, 8'd2, 4'd0, 8'h55);
      send_request(CMD_LOAD, 8'd3, 4'h8, 8'hAA);
      send_request(CMD_LOAD, 8'd4, 4'd3, 8'h01);
      send_request(CMD_LOAD, 8'd5, 4'hF, 8'hFE);
      send_request(CMD_LOAD, 8'd255, 4'd7, 8'h80);

      set_registers(3, 1'b1, 6);
      send_request(CMD_FLUSH_FORCE, 8'd0, 4'd0, 8'h00);
      send_request(CMD_PROPOSE, 8'd1, 4'd5, 8'h00);
      send_request(CMD_PROPOSE, 8'd1, 4'd6, 8'h03);
      send_request(CMD_PROPOSE, 8'd1, 4'hF, 8'h00);   // restores: entry goes
      send_request(CMD_PROPOSE, 8'd0, 4'hF, 8'hFF);
      send_request(CMD_PROPOSE, 8'd2, 4'd1, 8'h55);
      send_request(CMD_PROPOSE, 8'd3, 4'd4, 8'h00);
      send_request(CMD_PROPOSE, 8'd0, 4'd7, 8'hFF);   // removal of the first entry, not the last
      send_request(CMD_PROPOSE, 8'd6, 4'd2, 8'h10);   // beyond the models in use
      send_request(CMD_FLUSH_DUE, 8'd0, 4'd0, 8'h00);
      send_request(CMD_PROPOSE, 8'd4, 4'hF, 8'h01);
      send_request(CMD_FLUSH_DUE, 8'd0, 4'd0, 8'h00);

      set_registers(0, 1'b1, 6);
      send_request(CMD_FLUSH_DUE, 8'd0, 4'd0, 8'h00);

      set_registers(63, 1'b1, 6);
      send_request(CMD_PROPOSE, 8'd1, 4'd2, 8'h33);
      send_request(CMD_FLUSH_DUE, 8'd0, 4'd0, 8'h00);
      send_request(CMD_FLUSH_FORCE, 8'd0, 4'd0, 8'h00);

      run_phase(4, 1'b1, 20, 70, 60, 15);
      run_phase(32, 1'b1, 48, 80, 80, 5);
      // responses held back while requests keep coming: the block must stall
      rsp_hold   = 1'b1;
      req_steady = 1'b1;
      repeat (12) random_request(80, 5);
      run_phase(1, 1'b0, 40, 70, 85, 3);
      run_phase(0, 1'b1, 8, 35, 50, 25);
      run_phase(63, 1'b1, 511, 35, 70, 10);
      run_phase(16, 1'b1, 256, 50, 75, 8);
      run_phase(2, 1'b1, 3, 35, 60, 15);
      run_phase(1, 1'b0, 0, 20, 60, 20);

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Run: %0d requests under %0d register settings, model counts 0 to 511.",
               requests_sent, settings_used);
      $display("Seen: %0d flushes, %0d proposals dropped on a full buffer, %0d removals.",
               flush_total, drop_total, removal_total);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/clcb_pkg.sv
rtl/core/clcb_req_if.sv
rtl/core/clcb_rsp_if.sv
rtl/core/clcb_ram.sv
rtl/core/clcb_datapath.sv
rtl/core/clcb_ctrl.sv
rtl/core/coalescing_level_change_buffer_unit.sv
rtl/core/clcb_checker.sv
tb/level_change_checker.sv
tb/testbench.sv
